>>> sv/mvm_pkg.sv
// Shared types and constants for the matrix-vector multiplier.
// No dependencies; every other file in sv/ except mvm_ram refers to this package.
package mvm_pkg;

    localparam int MAX_ROWS_DEF = 16;
    localparam int MAX_COLS_DEF = 16;

    localparam int CFG_W     = 5;   // width of row_count / col_count
    localparam int CFG_IDX_W = 1;   // two registers
    localparam int VALUE_W   = 32;  // Q16.16 element
    localparam int ROW_IDX_W = 4;
    localparam int DOT_W     = 48;  // Q32.16 result
    localparam int ACC_W     = 64;
    localparam int FRAC_BITS = 16;

    // request opcodes
    localparam logic OP_MATRIX = 1'b0;
    localparam logic OP_VECTOR = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_EMIT
    } seq_state_t;

    // travels down the MAC pipeline with each operand pair
    typedef struct packed {
        logic valid;
        logic first;   // first column of a row: restart the sum
        logic last;    // last column of a row: sum is final after this one
    } mac_tag_t;

    // sequencer -> output register
    typedef struct packed {
        logic                 valid;
        logic [ROW_IDX_W-1:0] row_index;
        logic                 last;
    } emit_t;

endpackage

>>> sv/matrix_vector_multiply.sv
// Top level of the matrix-vector multiplier: stores, sequencer, MAC, output register.
// Depends on mvm_pkg, mvm_ram, mvm_mac and mvm_seq.
//   Input channel (s_valid/s_ready, s_op, s_value): each request loads one signed
//   Q16.16 element. s_op = 0 loads the next matrix element (row-major), s_op = 1
//   the next vector element. Both kinds are accepted only while the sequencer is idle.
//   The vector request that completes col_count elements starts a run: for each
//   row the MAC walks the columns, one element per cycle, then the saturated
//   Q32.16 sum is placed on the result channel (m_valid/m_ready, m_row_index,
//   m_dot_product, m_last), rows in order, m_last on the final row.
//   Per row: the columns are issued, read, multiply and accumulate drain, and the
//   sum is handed to the output register. s_ready is low from the completing
//   request for the whole run; the single MAC serves all rows in turn.
//   Stall: a result waits in the output register; while it is not taken the
//   sequencer holds before the next row. After the last row is loaded into the
//   output register, s_ready rises even if that result is still waiting.
//   Configuration: cfg_we writes cfg_data to register cfg_index (0 row_count,
//   1 col_count) in the same cycle; write only while idle.
//   Reset (aresetn low, synchronous): fill counts cleared, row_count and
//   col_count return to 1, output empty. Store contents are left as they are.
module matrix_vector_multiply #(
    parameter int MAX_ROWS = mvm_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = mvm_pkg::MAX_COLS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration
    input  logic                                cfg_we,
    input  logic [mvm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mvm_pkg::CFG_W-1:0]           cfg_data,
    // element requests
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_op,
    input  logic signed [mvm_pkg::VALUE_W-1:0]  s_value,
    // row results
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [mvm_pkg::ROW_IDX_W-1:0]       m_row_index,
    output logic signed [mvm_pkg::DOT_W-1:0]    m_dot_product,
    output logic                                m_last
);

    localparam int MAT_DEPTH = MAX_ROWS * MAX_COLS;
    localparam int MAW = (MAT_DEPTH > 1) ? $clog2(MAT_DEPTH) : 1;
    localparam int VAW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    logic                               mat_wr_en;
    logic [MAW-1:0]                     mat_wr_addr;
    logic                               vec_wr_en;
    logic [VAW-1:0]                     vec_wr_addr;
    logic                               rd_en;
    logic [MAW-1:0]                     mat_rd_addr;
    logic [VAW-1:0]                     vec_rd_addr;
    logic [mvm_pkg::VALUE_W-1:0]        mat_rd_data;
    logic [mvm_pkg::VALUE_W-1:0]        vec_rd_data;
    mvm_pkg::mac_tag_t                  issue_tag;
    mvm_pkg::emit_t                     emit;
    logic                               mac_done;
    logic signed [mvm_pkg::DOT_W-1:0]   sum_sat;
    logic                               out_free;

    // output register
    logic                               m_valid_reg;
    logic [mvm_pkg::ROW_IDX_W-1:0]      m_row_index_reg;
    logic signed [mvm_pkg::DOT_W-1:0]   m_dot_product_reg;
    logic                               m_last_reg;

    mvm_seq #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_op        (s_op),
        .mat_wr_en   (mat_wr_en),
        .mat_wr_addr (mat_wr_addr),
        .vec_wr_en   (vec_wr_en),
        .vec_wr_addr (vec_wr_addr),
        .rd_en       (rd_en),
        .mat_rd_addr (mat_rd_addr),
        .vec_rd_addr (vec_rd_addr),
        .issue_tag   (issue_tag),
        .mac_done    (mac_done),
        .out_free    (out_free),
        .emit        (emit)
    );

    // matrix store, row-major
    mvm_ram #(
        .WIDTH (mvm_pkg::VALUE_W),
        .DEPTH (MAT_DEPTH)
    ) u_mat_ram (
        .clk     (aclk),
        .wr_en   (mat_wr_en),
        .wr_addr (mat_wr_addr),
        .wr_data (s_value),
        .rd_en   (rd_en),
        .rd_addr (mat_rd_addr),
        .rd_data (mat_rd_data)
    );

    // vector store
    mvm_ram #(
        .WIDTH (mvm_pkg::VALUE_W),
        .DEPTH (MAX_COLS)
    ) u_vec_ram (
        .clk     (aclk),
        .wr_en   (vec_wr_en),
        .wr_addr (vec_wr_addr),
        .wr_data (s_value),
        .rd_en   (rd_en),
        .rd_addr (vec_rd_addr),
        .rd_data (vec_rd_data)
    );

    mvm_mac u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .issue_tag (issue_tag),
        .mat_data  (mat_rd_data),
        .vec_data  (vec_rd_data),
        .done      (mac_done),
        .sum_sat   (sum_sat)
    );

    // slot can take a new row when empty or being drained this cycle
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit.valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit.valid) begin
            m_row_index_reg   <= emit.row_index;
            m_dot_product_reg <= sum_sat;
            m_last_reg        <= emit.last;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_row_index   = m_row_index_reg;
    assign m_dot_product = m_dot_product_reg;
    assign m_last        = m_last_reg;

endmodule

>>> sv/mvm_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module mvm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/mvm_mac.sv
// Shared multiply-accumulate unit: registered 32x32 multiply, 64-bit accumulate,
// 48-bit saturation. Uses mvm_pkg types and widths.
module mvm_mac (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  mvm_pkg::mac_tag_t                 issue_tag,   // aligned with RAM read issue
    input  logic signed [mvm_pkg::VALUE_W-1:0] mat_data,
    input  logic signed [mvm_pkg::VALUE_W-1:0] vec_data,
    output logic                              done,        // row sum final
    output logic signed [mvm_pkg::DOT_W-1:0]  sum_sat
);

    localparam int AW = mvm_pkg::ACC_W;
    localparam int DW = mvm_pkg::DOT_W;

    mvm_pkg::mac_tag_t      tag_d1_reg;   // matches RAM read data
    mvm_pkg::mac_tag_t      tag_d2_reg;   // matches product_reg
    logic signed [AW-1:0]   product_reg;
    logic signed [AW-1:0]   product_next;
    logic signed [AW-1:0]   term;
    logic signed [AW-1:0]   acc_reg;
    logic signed [AW-1:0]   acc_next;
    logic                   done_reg;

    assign product_next = mat_data * vec_data;
    // arithmetic shift gives floor division by 2^16
    assign term     = product_reg >>> mvm_pkg::FRAC_BITS;
    assign acc_next = tag_d2_reg.first ? term : acc_reg + term;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_d1_reg <= '0;
            tag_d2_reg <= '0;
            done_reg   <= 1'b0;
        end else begin
            tag_d1_reg <= issue_tag;
            tag_d2_reg <= tag_d1_reg;
            done_reg   <= tag_d2_reg.valid && tag_d2_reg.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (tag_d1_reg.valid) begin
            product_reg <= product_next;
        end
        if (tag_d2_reg.valid) begin
            acc_reg <= acc_next;
        end
    end

    // saturate to 48 bits: overflow when bits 63..47 disagree
    always_comb begin
        if (!acc_reg[AW-1] && (|acc_reg[AW-2:DW-1])) begin
            sum_sat = {1'b0, {(DW-1){1'b1}}};
        end else if (acc_reg[AW-1] && !(&acc_reg[AW-2:DW-1])) begin
            sum_sat = {1'b1, {(DW-1){1'b0}}};
        end else begin
            sum_sat = acc_reg[DW-1:0];
        end
    end

    assign done = done_reg;

endmodule

>>> sv/mvm_seq.sv
// Sequencer: configuration registers, fill counters, store addressing and the
// row/column loop that feeds the MAC. Uses mvm_pkg types and constants.
module mvm_seq #(
    parameter int MAX_ROWS = mvm_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = mvm_pkg::MAX_COLS_DEF,
    localparam int MAW = (MAX_ROWS * MAX_COLS > 1) ? $clog2(MAX_ROWS * MAX_COLS) : 1,
    localparam int VAW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [mvm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mvm_pkg::CFG_W-1:0]          cfg_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_op,
    output logic                               mat_wr_en,
    output logic [MAW-1:0]                     mat_wr_addr,
    output logic                               vec_wr_en,
    output logic [VAW-1:0]                     vec_wr_addr,
    output logic                               rd_en,
    output logic [MAW-1:0]                     mat_rd_addr,
    output logic [VAW-1:0]                     vec_rd_addr,
    output mvm_pkg::mac_tag_t                  issue_tag,
    input  logic                               mac_done,
    input  logic                               out_free,
    output mvm_pkg::emit_t                     emit
);

    localparam int RW  = $clog2(MAX_ROWS + 1);
    localparam int CW  = $clog2(MAX_COLS + 1);
    localparam int TW  = RW + CW;
    localparam int RIW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int MFW = $clog2(MAX_ROWS * MAX_COLS + 1);
    localparam int VFW = $clog2(MAX_COLS + 1);

    mvm_pkg::seq_state_t        state_reg, state_next;
    logic [mvm_pkg::CFG_W-1:0]  row_count_reg;
    logic [mvm_pkg::CFG_W-1:0]  col_count_reg;
    logic [MFW-1:0]             mfill_reg, mfill_next;
    logic [VFW-1:0]             vfill_reg, vfill_next;
    logic [RIW-1:0]             r_reg, r_next;
    logic [VAW-1:0]             c_reg, c_next;
    logic [MAW-1:0]             maddr_reg, maddr_next;

    logic [RW-1:0]  rows;
    logic [CW-1:0]  cols;
    logic [TW-1:0]  total;
    logic [MFW-1:0] midx;
    logic [VFW-1:0] vidx;
    logic           accept;
    logic           vec_complete;
    logic           c_last;
    logic           r_last;

    // register values in use, clamped to 1..MAX
    assign rows = (row_count_reg == '0) ? RW'(1) :
                  (32'(row_count_reg) > MAX_ROWS) ? RW'(MAX_ROWS) : RW'(row_count_reg);
    assign cols = (col_count_reg == '0) ? CW'(1) :
                  (32'(col_count_reg) > MAX_COLS) ? CW'(MAX_COLS) : CW'(col_count_reg);
    assign total = TW'(rows) * TW'(cols);

    // overfill wraps to entry 0
    assign midx = (32'(mfill_reg) >= 32'(total)) ? '0 : mfill_reg;
    assign vidx = (32'(vfill_reg) >= 32'(cols)) ? '0 : vfill_reg;
    assign vec_complete = (32'(vidx) + 32'd1 == 32'(cols));

    assign s_ready = (state_reg == mvm_pkg::ST_IDLE);
    assign accept  = s_valid && s_ready;

    assign mat_wr_en   = accept && (s_op == mvm_pkg::OP_MATRIX);
    assign mat_wr_addr = midx[MAW-1:0];
    assign vec_wr_en   = accept && (s_op == mvm_pkg::OP_VECTOR);
    assign vec_wr_addr = vidx[VAW-1:0];

    assign mat_rd_addr = maddr_reg;
    assign vec_rd_addr = c_reg;
    assign c_last = (32'(c_reg) + 32'd1 == 32'(cols));
    assign r_last = (32'(r_reg) + 32'd1 == 32'(rows));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg <= mvm_pkg::CFG_W'(1);
            col_count_reg <= mvm_pkg::CFG_W'(1);
        end else if (cfg_we) begin
            case (cfg_index)
                mvm_pkg::REG_ROW_COUNT: row_count_reg <= cfg_data;
                mvm_pkg::REG_COL_COUNT: col_count_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mvm_pkg::ST_IDLE;
            mfill_reg <= '0;
            vfill_reg <= '0;
            r_reg     <= '0;
            c_reg     <= '0;
            maddr_reg <= '0;
        end else begin
            state_reg <= state_next;
            mfill_reg <= mfill_next;
            vfill_reg <= vfill_next;
            r_reg     <= r_next;
            c_reg     <= c_next;
            maddr_reg <= maddr_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        mfill_next = mfill_reg;
        vfill_next = vfill_reg;
        r_next     = r_reg;
        c_next     = c_reg;
        maddr_next = maddr_reg;
        rd_en      = 1'b0;
        issue_tag  = '0;
        emit       = '0;

        case (state_reg)
            mvm_pkg::ST_IDLE: begin
                if (mat_wr_en) begin
                    mfill_next = midx + MFW'(1);
                end
                if (vec_wr_en) begin
                    vfill_next = vidx + VFW'(1);
                    if (vec_complete) begin
                        r_next     = '0;
                        c_next     = '0;
                        maddr_next = '0;
                        state_next = mvm_pkg::ST_ISSUE;
                    end
                end
            end
            mvm_pkg::ST_ISSUE: begin
                rd_en           = 1'b1;
                issue_tag.valid = 1'b1;
                issue_tag.first = (c_reg == '0);
                issue_tag.last  = c_last;
                maddr_next      = maddr_reg + MAW'(1);
                if (c_last) begin
                    c_next     = '0;
                    state_next = mvm_pkg::ST_DRAIN;
                end else begin
                    c_next = c_reg + VAW'(1);
                end
            end
            mvm_pkg::ST_DRAIN: begin
                if (mac_done) begin
                    state_next = mvm_pkg::ST_EMIT;
                end
            end
            mvm_pkg::ST_EMIT: begin
                if (out_free) begin
                    emit.valid     = 1'b1;
                    emit.row_index = mvm_pkg::ROW_IDX_W'(r_reg);
                    emit.last      = r_last;
                    if (r_last) begin
                        mfill_next = '0;
                        vfill_next = '0;
                        state_next = mvm_pkg::ST_IDLE;
                    end else begin
                        r_next     = r_reg + RIW'(1);
                        state_next = mvm_pkg::ST_ISSUE;
                    end
                end
            end
            default: begin
                state_next = mvm_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> sv/mvm_checker.sv
// Port-level checks for matrix_vector_multiply, bound to the top level.
// Depends on mvm_pkg and the top-level port names.
module mvm_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic                                s_op,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic [mvm_pkg::ROW_IDX_W-1:0]       m_row_index,
    input logic signed [mvm_pkg::DOT_W-1:0]    m_dot_product,
    input logic                                m_last
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_dot_product)
            && $stable(m_row_index) && $stable(m_last))
        else $error("result changed while stalled");

    // a run is still busy while a non-final row result is pending
    a_busy_mid_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last |-> !s_ready)
        else $error("ready during a run");

    // a matrix load never starts a result
    a_matrix_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_op == mvm_pkg::OP_MATRIX) |=> !$rose(m_valid))
        else $error("result after matrix load");

    // reset empties the output
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind matrix_vector_multiply mvm_checker u_mvm_checker (.*);

>>> verif/matrix_vector_multiply_test.sv
// Self-checking testbench for matrix_vector_multiply: directed table plus random shape phases.
// Depends on mvm_pkg and the matrix_vector_multiply RTL; nothing else.
`timescale 1ns / 100ps

module matrix_vector_multiply_test;

    // Run sizing. The watchdog limit is many times the longest quiet stretch: the long
    // receiver hold plus one sender gap and one row.
    localparam int  RANDOM_ITEMS   = 140;
    localparam int  RANDOM_ROWS    = 40;
    localparam int  SETTLE_CYCLES  = 4;     // lets a last matrix or partial-vector load settle
    localparam int  RUN_TAIL       = 40;    // two rows of the widest shape
    localparam int  LONG_HOLD      = 400;
    localparam int  WATCHDOG_LIMIT = 3000;
    localparam int  REPORT_LIMIT   = 10;

    localparam longint DOT_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint DOT_LO = -DOT_HI - 1;

    localparam int MAT_ENTRIES = mvm_pkg::MAX_ROWS_DEF * mvm_pkg::MAX_COLS_DEF;

    typedef enum logic {
        STEP_ELEMENT,
        STEP_REGISTER
    } step_kind_t;

    // one row of the directed table
    typedef struct packed {
        step_kind_t                           kind;
        logic [mvm_pkg::CFG_IDX_W-1:0]        reg_index;
        logic [mvm_pkg::CFG_W-1:0]            reg_data;
        logic                                 op;
        logic signed [mvm_pkg::VALUE_W-1:0]   value;
        logic                                 typed;      // dot product below is the expectation
        logic signed [mvm_pkg::DOT_W-1:0]     typed_dot;
    } directed_step_t;

    typedef struct packed {
        logic [mvm_pkg::ROW_IDX_W-1:0]        row_index;
        logic signed [mvm_pkg::DOT_W-1:0]     dot;
        logic                                 last;
    } row_result_t;

    // DUT ports; every input has a known value from time zero
    logic                                 aclk = 1'b0;
    logic                                 aresetn = 1'b0;
    logic                                 cfg_we = 1'b0;
    logic [mvm_pkg::CFG_IDX_W-1:0]        cfg_index = mvm_pkg::REG_ROW_COUNT;
    logic [mvm_pkg::CFG_W-1:0]            cfg_data = '0;
    logic                                 s_valid = 1'b0;
    logic                                 s_ready;
    logic                                 s_op = mvm_pkg::OP_MATRIX;
    logic signed [mvm_pkg::VALUE_W-1:0]   s_value = '0;
    logic                                 m_valid;
    logic                                 m_ready = 1'b0;
    logic [mvm_pkg::ROW_IDX_W-1:0]        m_row_index;
    logic signed [mvm_pkg::DOT_W-1:0]     m_dot_product;
    logic                                 m_last;

    // Shadow copy of the block: registers as written (raw 5-bit values), stores,
    // fill counters, and a written flag per entry so that stimulus never makes the
    // block read an entry that was never loaded.
    logic [mvm_pkg::CFG_W-1:0]            shadow_rows = mvm_pkg::CFG_W'(1);
    logic [mvm_pkg::CFG_W-1:0]            shadow_cols = mvm_pkg::CFG_W'(1);
    logic signed [mvm_pkg::VALUE_W-1:0]   shadow_matrix [MAT_ENTRIES];
    logic signed [mvm_pkg::VALUE_W-1:0]   shadow_vector [mvm_pkg::MAX_COLS_DEF];
    bit                                   matrix_written [MAT_ENTRIES];
    bit                                   vector_written [mvm_pkg::MAX_COLS_DEF];
    int                                   matrix_fill = 0;
    int                                   vector_fill = 0;

    row_result_t                 pending_rows [$];   // row results still owed by the DUT
    directed_step_t              directed_rows [$];

    int burst_left     = 0;
    int rows_predicted = 0;
    int rows_checked   = 0;
    int mismatch_count = 0;
    int random_items   = 0;
    int directed_items = 0;
    int shape_count    = 0;
    int quiet_cycles   = 0;

    // receiver side: long hold requested by the stimulus, counted out locally
    int          hold_token  = 0;
    int          hold_seen   = 0;
    int          hold_left   = 0;
    logic [15:0] ready_pattern = '1;
    int          pattern_pos = 0;

    matrix_vector_multiply i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_row_index   (m_row_index),
        .m_dot_product (m_dot_product),
        .m_last        (m_last)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // ---------------------------------------------------------------------------
    // Prediction
    // ---------------------------------------------------------------------------

    // 0 acts as 1, anything above the store size saturates
    function automatic int clamp_dim(input logic [mvm_pkg::CFG_W-1:0] raw, input int limit);
        if (raw == 0) return 1;
        if (raw > limit) return limit;
        return int'(raw);
    endfunction

    // Applies one accepted request to the shadow state. When it completes the vector,
    // queues one saturated dot product per row and returns how many.
    function automatic int predict_dot_products(input logic op,
                                                input logic signed [mvm_pkg::VALUE_W-1:0] value);
        int          rows;
        int          cols;
        int          slot;
        longint      sum;
        row_result_t res;
        rows = clamp_dim(shadow_rows, mvm_pkg::MAX_ROWS_DEF);
        cols = clamp_dim(shadow_cols, mvm_pkg::MAX_COLS_DEF);
        if (op == mvm_pkg::OP_MATRIX) begin
            // row-major with the current row length; wraps to 0 once the matrix is full
            slot = (matrix_fill >= rows * cols) ? 0 : matrix_fill;
            shadow_matrix[slot]  = value;
            matrix_written[slot] = 1'b1;
            matrix_fill = slot + 1;
            return 0;
        end
        // vector count past a shrunk col_count restarts at 0
        slot = (vector_fill >= cols) ? 0 : vector_fill;
        shadow_vector[slot]  = value;
        vector_written[slot] = 1'b1;
        vector_fill = slot + 1;
        if (slot + 1 != cols) return 0;
        for (int r = 0; r < rows; r++) begin
            sum = 0;
            // each Q32.32 product is floored back to Q.16 before it is summed
            for (int c = 0; c < cols; c++)
                sum += (longint'(shadow_matrix[r * cols + c]) *
                        longint'(shadow_vector[c])) >>> mvm_pkg::FRAC_BITS;
            if (sum > DOT_HI) sum = DOT_HI;
            else if (sum < DOT_LO) sum = DOT_LO;
            res.row_index = mvm_pkg::ROW_IDX_W'(r);
            res.dot       = sum[mvm_pkg::DOT_W-1:0];
            res.last      = (r == rows - 1);
            pending_rows.push_back(res);
        end
        matrix_fill = 0;
        vector_fill = 0;
        return rows;
    endfunction

    // True unless the next vector request would complete the vector and make the
    // block read an entry that was never loaded.
    function automatic bit completion_reads_written();
        int rows;
        int cols;
        int slot;
        rows = clamp_dim(shadow_rows, mvm_pkg::MAX_ROWS_DEF);
        cols = clamp_dim(shadow_cols, mvm_pkg::MAX_COLS_DEF);
        slot = (vector_fill >= cols) ? 0 : vector_fill;
        if (slot + 1 != cols) return 1'b1;
        for (int c = 0; c < cols - 1; c++)
            if (!vector_written[c]) return 1'b0;
        for (int i = 0; i < rows * cols; i++)
            if (!matrix_written[i]) return 1'b0;
        return 1'b1;
    endfunction

    // ---------------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------------

    function automatic directed_step_t load(input logic op,
                                            input logic signed [mvm_pkg::VALUE_W-1:0] value);
        directed_step_t s;
        s       = '0;
        s.kind  = STEP_ELEMENT;
        s.op    = op;
        s.value = value;
        return s;
    endfunction

    function automatic directed_step_t load_checked(
        input logic op,
        input logic signed [mvm_pkg::VALUE_W-1:0] value,
        input logic signed [mvm_pkg::DOT_W-1:0] dot);
        directed_step_t s;
        s           = load(op, value);
        s.typed     = 1'b1;
        s.typed_dot = dot;
        return s;
    endfunction

    function automatic directed_step_t set_reg(input logic [mvm_pkg::CFG_IDX_W-1:0] idx,
                                               input logic [mvm_pkg::CFG_W-1:0] data);
        directed_step_t s;
        s           = '0;
        s.kind      = STEP_REGISTER;
        s.reg_index = idx;
        s.reg_data  = data;
        return s;
    endfunction

    // extremes, -1 LSB and zero often; full-range words; otherwise within +-8.0
    function automatic logic signed [mvm_pkg::VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2:       return '0;
            3:       return -32'sd1;
            4, 5:    return $urandom();
            default: return $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
        endcase
    endfunction

    // wide: 16 or an out-of-range value that saturates to 16; else mostly 1..4, sometimes 0
    function automatic logic [mvm_pkg::CFG_W-1:0] pick_dim(input bit wide);
        if (wide)
            return ($urandom_range(0, 1) != 0) ? mvm_pkg::CFG_W'(16) :
                                                 mvm_pkg::CFG_W'($urandom_range(17, 31));
        return ($urandom_range(0, 7) == 0) ? mvm_pkg::CFG_W'(0) :
                                             mvm_pkg::CFG_W'($urandom_range(1, 4));
    endfunction

    // Offers one request. The sender runs in bursts; a new burst may start after a
    // gap with s_valid low. The shadow model advances at acceptance. A typed row
    // replaces the predicted result with the value written in the table.
    task automatic offer_request(input logic op,
                                 input logic signed [mvm_pkg::VALUE_W-1:0] value,
                                 input logic typed,
                                 input logic signed [mvm_pkg::DOT_W-1:0] typed_dot);
        int gap;
        int produced;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? 64 : $urandom_range(1, 16);
        end
        s_op    <= op;
        s_value <= value;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        burst_left--;
        produced = predict_dot_products(op, value);
        rows_predicted += produced;
        // typed rows only appear with a single-row shape
        if (typed && produced != 0)
            pending_rows[pending_rows.size() - 1] = '{row_index: '0, dot: typed_dot,
                                                      last: 1'b1};
    endtask

    task automatic offer_random(input logic op);
        logic use_op;
        use_op = op;
        if (use_op == mvm_pkg::OP_VECTOR && !completion_reads_written())
            use_op = mvm_pkg::OP_MATRIX;
        offer_request(use_op, pick_value(), 1'b0, '0);
        random_items++;
    endtask

    // Registers change only when the block is idle: sender quiet, all rows
    // delivered, and a few cycles for a last load that produced no result.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_rows.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [mvm_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [mvm_pkg::CFG_W-1:0] data);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        if (idx == mvm_pkg::REG_ROW_COUNT) shadow_rows = data;
        else shadow_cols = data;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // One run on the current shape. Mostly a clean matrix-then-vector load; the
    // rest overfill the matrix, load it short (stale entries reused), stop the
    // vector early, or mix the ops at random. The pressure shape always runs clean
    // so that its results back up behind the long receiver hold.
    task automatic emit_run(input int rows, input int cols);
        int style;
        int matrix_items;
        int vector_items;
        style        = (shape_count == 0) ? 0 : $urandom_range(0, 9);
        matrix_items = rows * cols;
        vector_items = cols;
        case (style)
            6: begin
                repeat (matrix_items + vector_items) offer_random(1'($urandom_range(0, 1)));
                return;
            end
            7: matrix_items += $urandom_range(1, 3);
            8: matrix_items -= $urandom_range(1, rows * cols);
            9: vector_items = $urandom_range(0, cols - 1);
            default: ;
        endcase
        repeat (matrix_items) offer_random(mvm_pkg::OP_MATRIX);
        repeat (vector_items) offer_random(mvm_pkg::OP_VECTOR);
    endtask

    // ---------------------------------------------------------------------------
    // Receiver: rotating ready pattern, re-drawn each time it wraps (all ready,
    // random, or sparse), unless a long hold has been requested.
    // ---------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (hold_token != hold_seen) begin
            hold_seen <= hold_token;
            hold_left <= LONG_HOLD;
            m_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ready_pattern[pattern_pos];
            if (pattern_pos == 15) begin
                pattern_pos <= 0;
                case ($urandom_range(0, 3))
                    0:       ready_pattern <= '1;
                    1:       ready_pattern <= 16'($urandom()) | 16'h0101;
                    2:       ready_pattern <= 16'($urandom() & $urandom()) | 16'h8001;
                    default: ready_pattern <= 16'($urandom());
                endcase
            end else begin
                pattern_pos <= pattern_pos + 1;
            end
        end
    end

    // ---------------------------------------------------------------------------
    // Result check: every accepted row against the oldest expectation
    // ---------------------------------------------------------------------------
    always @(posedge aclk) begin : result_check
        row_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_rows.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("%0t: unexpected row result: row %0d dot %0d last %0b",
                             $realtime, m_row_index, m_dot_product, m_last);
            end else begin
                want = pending_rows.pop_front();
                rows_checked++;
                if (m_row_index !== want.row_index || m_dot_product !== want.dot ||
                    m_last !== want.last) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("%0t: expected row %0d dot %0d last %0b, got %0d %0d %0b",
                                 $realtime, want.row_index, want.dot, want.last,
                                 m_row_index, m_dot_product, m_last);
                end
            end
        end
    end

    // Watchdog: too long without any request or result moving means a hang.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d rows still owed",
                     $realtime, WATCHDOG_LIMIT, pending_rows.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------------
    initial begin : stimulus
        logic [mvm_pkg::CFG_W-1:0] rows_raw;
        logic [mvm_pkg::CFG_W-1:0] cols_raw;
        int                        pick;
        int                        runs;

        // Directed table. Shape is 1x1 after reset, so single products can be
        // written down directly: unity, min*min, max*max, min*max, and -1 LSB times
        // +1 LSB (floor gives -1, not 0). Then two-column and three-column sums that
        // saturate high and low, zero registers acting as 1 with a matrix overfill,
        // and a vector left longer than a shrunk col_count.
        directed_rows = '{
            load        (mvm_pkg::OP_MATRIX, 32'sh0001_0000),
            load_checked(mvm_pkg::OP_VECTOR, 32'sh0001_0000, 48'sd65536),
            load        (mvm_pkg::OP_MATRIX, 32'sh8000_0000),
            load_checked(mvm_pkg::OP_VECTOR, 32'sh8000_0000, 48'sd70368744177664),
            load        (mvm_pkg::OP_MATRIX, 32'sh7FFF_FFFF),
            load_checked(mvm_pkg::OP_VECTOR, 32'sh7FFF_FFFF, 48'sd70368744112128),
            load        (mvm_pkg::OP_MATRIX, 32'sh8000_0000),
            load_checked(mvm_pkg::OP_VECTOR, 32'sh7FFF_FFFF, -48'sd70368744144896),
            load        (mvm_pkg::OP_MATRIX, 32'shFFFF_FFFF),
            load_checked(mvm_pkg::OP_VECTOR, 32'sh0000_0001, -48'sd1),
            set_reg     (mvm_pkg::REG_COL_COUNT, mvm_pkg::CFG_W'(2)),
            load        (mvm_pkg::OP_MATRIX, 32'sh8000_0000),
            load        (mvm_pkg::OP_MATRIX, 32'sh8000_0000),
            load        (mvm_pkg::OP_VECTOR, 32'sh8000_0000),
            load_checked(mvm_pkg::OP_VECTOR, 32'sh8000_0000, 48'sh7FFF_FFFF_FFFF),
            set_reg     (mvm_pkg::REG_COL_COUNT, mvm_pkg::CFG_W'(3)),
            load        (mvm_pkg::OP_MATRIX, 32'sh8000_0000),
            load        (mvm_pkg::OP_MATRIX, 32'sh8000_0000),
            load        (mvm_pkg::OP_MATRIX, 32'sh8000_0000),
            load        (mvm_pkg::OP_VECTOR, 32'sh7FFF_FFFF),
            load        (mvm_pkg::OP_VECTOR, 32'sh7FFF_FFFF),
            load_checked(mvm_pkg::OP_VECTOR, 32'sh7FFF_FFFF, 48'sh8000_0000_0000),
            set_reg     (mvm_pkg::REG_ROW_COUNT, mvm_pkg::CFG_W'(0)),
            set_reg     (mvm_pkg::REG_COL_COUNT, mvm_pkg::CFG_W'(0)),
            load        (mvm_pkg::OP_MATRIX, 32'sh0003_0000),
            load        (mvm_pkg::OP_MATRIX, 32'shFFFE_8000),
            load        (mvm_pkg::OP_VECTOR, 32'sh0002_0000),
            set_reg     (mvm_pkg::REG_COL_COUNT, mvm_pkg::CFG_W'(3)),
            load        (mvm_pkg::OP_VECTOR, 32'sh0001_0000),
            load        (mvm_pkg::OP_VECTOR, 32'sh0002_0000),
            set_reg     (mvm_pkg::REG_COL_COUNT, mvm_pkg::CFG_W'(1)),
            load        (mvm_pkg::OP_VECTOR, 32'shFFFF_0000)
        };

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == STEP_REGISTER) begin
                write_register(directed_rows[i].reg_index, directed_rows[i].reg_data);
            end else begin
                offer_request(directed_rows[i].op, directed_rows[i].value,
                              directed_rows[i].typed, directed_rows[i].typed_dot);
                directed_items++;
            end
        end

        // Random shape phases. The first one has the full row count (possibly from
        // an out-of-range value) and a long receiver hold, so the output stalls and
        // the block backs up while requests keep coming. The second has the full
        // column count. Later shapes are mostly small.
        while (random_items < RANDOM_ITEMS || rows_predicted < RANDOM_ROWS) begin
            pick     = (shape_count < 2) ? shape_count : $urandom_range(2, 9);
            rows_raw = pick_dim(pick == 0);
            cols_raw = pick_dim(pick == 1);
            write_register(mvm_pkg::REG_ROW_COUNT, rows_raw);
            write_register(mvm_pkg::REG_COL_COUNT, cols_raw);
            if (shape_count == 0) hold_token <= hold_token + 1;
            runs = (shape_count == 0) ? 2 : (shape_count == 1) ? 1 : $urandom_range(1, 3);
            repeat (runs)
                emit_run(clamp_dim(rows_raw, mvm_pkg::MAX_ROWS_DEF),
                         clamp_dim(cols_raw, mvm_pkg::MAX_COLS_DEF));
            shape_count++;
        end

        wait_idle();
        repeat (RUN_TAIL) @(posedge aclk);

        if (pending_rows.size() != 0)
            $display("%0d expected row results never arrived", pending_rows.size());
        $display("Ran %0d directed and %0d random element requests over %0d random shapes",
                 directed_items, random_items, shape_count);
        $display("Checked %0d row results, %0d mismatches", rows_checked, mismatch_count);
        if (mismatch_count == 0 && pending_rows.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
